// ----- hdl/ltm_pkg.sv -----
// Shared constants, codes and control types of the lock table manager.
`timescale 1ns / 1ps
`default_nettype none
package ltm_pkg;

  localparam int NUM_LOCKS   = 32;
  localparam int NUM_CLIENTS = 16;

  localparam int FUNC_W   = 1;
  localparam int CLIENT_W = 4;
  localparam int IDX_W    = 5;
  localparam int STATUS_W = 2;
  localparam int LOCK_W   = (NUM_LOCKS > 1) ? $clog2(NUM_LOCKS) : 1;

  localparam logic [FUNC_W-1:0] FUNC_LOCK    = 1'b0;
  localparam logic [FUNC_W-1:0] FUNC_RELEASE = 1'b1;

  localparam logic [STATUS_W-1:0] ST_GRANTED     = 2'd0;
  localparam logic [STATUS_W-1:0] ST_NOT_GRANTED = 2'd1;
  localparam logic [STATUS_W-1:0] ST_YOURS       = 2'd2;
  localparam logic [STATUS_W-1:0] ST_PREVENT     = 2'd3;

  localparam logic [CLIENT_W-1:0] CLIENT_ZERO = 4'd0;
  localparam logic [CLIENT_W-1:0] CLIENT_ONE  = 4'd1;

  typedef struct packed {
    logic load;
    logic exec;
    logic second;
  } cmd_t;

  typedef struct packed {
    logic need_second;
  } sts_t;

endpackage
`default_nettype wire

// ----- hdl/ltm_ctrl.sv -----
// Controller state machine that sequences request capture, execution and the second word.
`timescale 1ns / 1ps
`default_nettype none
module ltm_ctrl (
  input  wire                clk_i,
  input  wire                rst_ni,
  input  wire                start,
  output logic               busy,
  input  wire ltm_pkg::sts_t sts_i,
  output ltm_pkg::cmd_t      cmd_o
);

  localparam logic [1:0] S_IDLE   = 2'd0;
  localparam logic [1:0] S_EXEC   = 2'd1;
  localparam logic [1:0] S_SECOND = 2'd2;

  logic [1:0] state_q, state_d;

  always_comb begin
    state_d = state_q;
    cmd_o   = '0;
    busy    = 1'b1;
    unique case (state_q)
      S_IDLE: begin
        busy = 1'b0;
        if (start) begin
          cmd_o.load = 1'b1;
          state_d    = S_EXEC;
        end
      end
      S_EXEC: begin
        cmd_o.exec = 1'b1;
        state_d    = sts_i.need_second ? S_SECOND : S_IDLE;
      end
      S_SECOND: begin
        cmd_o.second = 1'b1;
        state_d      = S_IDLE;
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

endmodule
`default_nettype wire

// ----- hdl/ltm_dp.sv -----
// Datapath holding the lock table, the waiting marks and the reply register.
`timescale 1ns / 1ps
`default_nettype none
module ltm_dp (
  input  wire                                 clk_i,
  input  wire                                 rst_ni,
  input  wire ltm_pkg::cmd_t                  cmd_i,
  output ltm_pkg::sts_t                       sts_o,
  input  wire  [ltm_pkg::FUNC_W-1:0]          func_i,
  input  wire  [ltm_pkg::CLIENT_W-1:0]        client_i,
  input  wire  [ltm_pkg::IDX_W-1:0]           lock_index_i,
  output logic                                valid_o,
  output logic [ltm_pkg::CLIENT_W-1:0]        dest_client_o,
  output logic [ltm_pkg::STATUS_W-1:0]        status_o,
  output logic [ltm_pkg::CLIENT_W-1:0]        holder_o,
  output logic                                livelock_o,
  output logic                                last_o
);

  localparam int NL = ltm_pkg::NUM_LOCKS;
  localparam int LW = ltm_pkg::LOCK_W;
  localparam int CW = ltm_pkg::CLIENT_W;
  localparam int SW = ltm_pkg::STATUS_W;

  logic [ltm_pkg::FUNC_W-1:0] req_func_q;
  logic [CW-1:0]              req_client_q;
  logic [ltm_pkg::IDX_W-1:0]  req_idx_q;

  logic [NL-1:0] taken_q, taken_d;
  logic [CW-1:0] owner_q [NL];
  logic [CW-1:0] owner_d [NL];

  logic          w0_v_q, w0_v_d, w1_v_q, w1_v_d;
  logic [LW-1:0] w0_idx_q, w0_idx_d, w1_idx_q, w1_idx_d;
  logic          halted_q, halted_d;
  logic          live_q, live_d;

  logic          valid_q, valid_d;
  logic [CW-1:0] dest_q, dest_d;
  logic [SW-1:0] status_q, status_d;
  logic [CW-1:0] holder_q, holder_d;
  logic          livelock_q, livelock_d;
  logic          last_q, last_d;

  logic [NL-1:0] own, hand;
  logic          client_ok, idx_ok, is_c0, is_c1, mark0, mark1;
  logic [LW-1:0] idx_e;

  assign client_ok = 32'(req_client_q) < 32'(ltm_pkg::NUM_CLIENTS);
  assign idx_ok    = 32'(req_idx_q) < 32'(NL);
  assign idx_e     = LW'(req_idx_q);
  assign is_c0     = req_client_q == ltm_pkg::CLIENT_ZERO;
  assign is_c1     = req_client_q == ltm_pkg::CLIENT_ONE;
  assign mark0     = is_c0 | w0_v_q;
  assign mark1     = is_c1 | w1_v_q;

  always_comb begin
    for (int i = 0; i < NL; i++) begin
      own[i]  = taken_q[i] && (owner_q[i] == req_client_q);
      hand[i] = own[i] && ((is_c0 && w1_v_q && (w1_idx_q == LW'(i))) ||
                           (is_c1 && w0_v_q && (w0_idx_q == LW'(i))));
    end
  end

  always_comb begin
    taken_d    = taken_q;
    owner_d    = owner_q;
    w0_v_d     = w0_v_q;
    w0_idx_d   = w0_idx_q;
    w1_v_d     = w1_v_q;
    w1_idx_d   = w1_idx_q;
    halted_d   = halted_q;
    live_d     = live_q;
    valid_d    = 1'b0;
    dest_d     = dest_q;
    status_d   = status_q;
    holder_d   = holder_q;
    livelock_d = livelock_q;
    last_d     = last_q;
    sts_o      = '0;
    if (cmd_i.exec && !halted_q && client_ok) begin
      if (req_func_q == ltm_pkg::FUNC_RELEASE) begin
        for (int i = 0; i < NL; i++) begin
          if (hand[i]) begin
            owner_d[i] = is_c0 ? ltm_pkg::CLIENT_ONE : ltm_pkg::CLIENT_ZERO;
          end else if (own[i]) begin
            taken_d[i] = 1'b0;
          end
        end
        if (|hand) begin
          valid_d    = 1'b1;
          dest_d     = is_c0 ? ltm_pkg::CLIENT_ONE : ltm_pkg::CLIENT_ZERO;
          status_d   = ltm_pkg::ST_GRANTED;
          holder_d   = '0;
          livelock_d = 1'b0;
          last_d     = 1'b1;
          if (is_c0) begin
            w1_v_d = 1'b0;
          end else begin
            w0_v_d = 1'b0;
          end
        end
      end else if (idx_ok) begin
        valid_d    = 1'b1;
        dest_d     = req_client_q;
        holder_d   = '0;
        livelock_d = 1'b0;
        last_d     = 1'b1;
        priority if (!taken_q[idx_e]) begin
          taken_d[idx_e] = 1'b1;
          owner_d[idx_e] = req_client_q;
          status_d       = ltm_pkg::ST_GRANTED;
        end else if (owner_q[idx_e] == req_client_q) begin
          status_d = ltm_pkg::ST_YOURS;
        end else begin
          status_d = ltm_pkg::ST_NOT_GRANTED;
          holder_d = owner_q[idx_e];
          if (mark0 && mark1) begin
            // Both low clients would wait: roll back the requester's mark.
            last_d            = 1'b0;
            sts_o.need_second = 1'b1;
            if (is_c0) begin
              w0_v_d = 1'b0;
            end else if (is_c1) begin
              w1_v_d = 1'b0;
            end
            live_d   = &taken_q;
            halted_d = &taken_q;
          end else if (is_c0) begin
            w0_v_d   = 1'b1;
            w0_idx_d = idx_e;
          end else if (is_c1) begin
            w1_v_d   = 1'b1;
            w1_idx_d = idx_e;
          end
        end
      end
    end else if (cmd_i.second) begin
      valid_d    = 1'b1;
      dest_d     = req_client_q;
      status_d   = ltm_pkg::ST_PREVENT;
      holder_d   = '0;
      livelock_d = live_q;
      last_d     = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      taken_q  <= '0;
      w0_v_q   <= 1'b0;
      w1_v_q   <= 1'b0;
      halted_q <= 1'b0;
      valid_q  <= 1'b0;
    end else begin
      taken_q  <= taken_d;
      w0_v_q   <= w0_v_d;
      w1_v_q   <= w1_v_d;
      halted_q <= halted_d;
      valid_q  <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      req_func_q   <= func_i;
      req_client_q <= client_i;
      req_idx_q    <= lock_index_i;
    end
    owner_q    <= owner_d;
    w0_idx_q   <= w0_idx_d;
    w1_idx_q   <= w1_idx_d;
    live_q     <= live_d;
    dest_q     <= dest_d;
    status_q   <= status_d;
    holder_q   <= holder_d;
    livelock_q <= livelock_d;
    last_q     <= last_d;
  end

  assign valid_o       = valid_q;
  assign dest_client_o = dest_q;
  assign status_o      = status_q;
  assign holder_o      = holder_q;
  assign livelock_o    = livelock_q;
  assign last_o        = last_q;

endmodule
`default_nettype wire

// ----- hdl/lock_table_manager_deadlock_guard.sv -----
// Top level of the lock table manager with its deadlock guard.
//
// A request is taken when start is high and busy is low. A lock request is
// captured, then the table is updated and its reply registered with the
// update; a request that hits the deadlock guard gives its prevent word in
// the cycle after the not-granted word. A release frees the client's entries
// but hands the one the other low client waits on to it, with at most one
// grant word to that client. Each result word is shown for exactly one cycle
// with valid_o high and cannot be held off, so the receiver must take it then.
// After a livelock word the block ignores all requests until reset.
`timescale 1ns / 1ps
`default_nettype none
module lock_table_manager_deadlock_guard (
  input  wire                                 clk_i,
  input  wire                                 rst_ni,
  input  wire                                 start,
  output logic                                busy,
  input  wire  [ltm_pkg::FUNC_W-1:0]          func_i,
  input  wire  [ltm_pkg::CLIENT_W-1:0]        client_i,
  input  wire  [ltm_pkg::IDX_W-1:0]           lock_index_i,
  output logic                                valid_o,
  output logic [ltm_pkg::CLIENT_W-1:0]        dest_client_o,
  output logic [ltm_pkg::STATUS_W-1:0]        status_o,
  output logic [ltm_pkg::CLIENT_W-1:0]        holder_o,
  output logic                                livelock_o,
  output logic                                last_o
);

  ltm_pkg::cmd_t cmd;
  ltm_pkg::sts_t sts;

  ltm_ctrl u_ctrl (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .start  (start),
    .busy   (busy),
    .sts_i  (sts),
    .cmd_o  (cmd)
  );

  ltm_dp u_dp (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cmd_i         (cmd),
    .sts_o         (sts),
    .func_i        (func_i),
    .client_i      (client_i),
    .lock_index_i  (lock_index_i),
    .valid_o       (valid_o),
    .dest_client_o (dest_client_o),
    .status_o      (status_o),
    .holder_o      (holder_o),
    .livelock_o    (livelock_o),
    .last_o        (last_o)
  );

endmodule
`default_nettype wire
